FILE: sv/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg
// Types and constants for the prefix-code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int CODE_W  = 16;
    localparam int LEN_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 16;
    localparam int SYM_W   = 8;
    localparam int ACC_W   = CODE_W + BYTE_W - 1;
    localparam int CNT_W   = 5;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_ENCODE = 1'b1;

    localparam logic [SYM_W-1:0] SYM_END = '0;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

    function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] n);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++) begin
            m[i] = (LEN_W'(i) < n);
        end
        return m;
    endfunction

endpackage

FILE: sv/prefix_code_bit_packer.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Prefix-code encoder: code table in a synchronous RAM, codes packed
// LSB-first into bytes, end-of-message flush with bit total.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat
// s_*      in   load (write table entry) or encode (look up and pack symbol)
// m_*      out  one stream byte, or the end-of-message result with bit_total
//
// The table read is registered; the packer then emits one beat per cycle while
// the output is free. An encode yields a beat for each byte it completes; the
// end-of-message encode also yields the partial or empty final beat.
// Loads write the table entry and produce no beat.
// Reset clears the table valid flags and the packer state.
// Either side may stall at any time; the read stage and output register hold.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer #(
    parameter int MAX_CODE_LEN = 16,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [pcbp_pkg::SYM_W-1:0]    s_symbol,
    input  logic [pcbp_pkg::CODE_W-1:0]   s_code_bits,
    input  logic [pcbp_pkg::LEN_W-1:0]    s_code_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcbp_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_byte_valid,
    output logic [pcbp_pkg::TOTAL_W-1:0]  m_bit_total,
    output logic                          m_last
);
    import pcbp_pkg::*;

    localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int EFF_LEN = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(EFF_LEN);
    localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(BYTE_W);

    // code table
    entry_t            mem [SYMBOL_COUNT];
    logic              vld_reg [SYMBOL_COUNT];
    entry_t            rd_data_reg;
    logic              rd_hit_reg;
    logic              rd_valid_reg;
    logic              rd_end_reg;

    // packer state
    logic [ACC_W-1:0]   acc_reg,  acc_next,  acc_e;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next,  cnt_e;
    logic [TOTAL_W-1:0] bc_reg,   bc_next,   bc_e;
    logic               end_reg,  end_next,  end_e;

    // output register
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               byte_valid_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               last_reg;

    logic               in_acc;
    logic               in_range;
    logic [IDX_W-1:0]   in_idx;
    logic               do_load;
    logic               do_read;
    logic [LEN_W-1:0]   ld_len;
    entry_t             ld_entry;
    entry_t             rd_entry;
    logic               out_free;
    logic               due;
    logic               emit;
    logic               emit_last;
    logic               absorb;

    assign in_acc   = s_valid && s_ready;
    assign in_range = ({1'b0, s_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign in_idx   = s_symbol[IDX_W-1:0];
    assign do_load  = in_acc && in_range && (s_req_type == REQ_LOAD);
    assign do_read  = in_acc && in_range && (s_req_type == REQ_ENCODE);

    assign ld_len         = (s_code_length > LEN_CAP) ? LEN_CAP : s_code_length;
    assign ld_entry.code  = s_code_bits & len_mask(ld_len);
    assign ld_entry.len   = ld_len;

    always_ff @(posedge aclk) begin
        if (do_load) begin
            mem[in_idx] <= ld_entry;
        end
        if (do_read) begin
            rd_data_reg <= mem[in_idx];
            rd_end_reg  <= (s_symbol == SYM_END);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
                vld_reg[i] <= 1'b0;
            end
            rd_hit_reg <= 1'b0;
        end else begin
            if (do_load) begin
                vld_reg[in_idx] <= 1'b1;
            end
            if (do_read) begin
                rd_hit_reg <= vld_reg[in_idx];
            end
        end
    end

    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

    // emission from the packer
    assign out_free  = !m_valid_reg || m_ready;
    assign due       = end_reg || (cnt_reg >= BYTE_CNT);
    assign emit      = due && out_free;
    assign emit_last = end_reg && (cnt_reg <= BYTE_CNT);

    always_comb begin
        acc_e = acc_reg;
        cnt_e = cnt_reg;
        bc_e  = bc_reg;
        end_e = end_reg;
        if (emit) begin
            if (emit_last) begin
                acc_e = '0;
                cnt_e = '0;
                bc_e  = '0;
                end_e = 1'b0;
            end else begin
                acc_e = acc_reg >> BYTE_W;
                cnt_e = cnt_reg - BYTE_CNT;
            end
        end
    end

    assign absorb = rd_valid_reg && !end_e && (cnt_e < BYTE_CNT);
    assign s_ready = !rd_valid_reg || absorb;

    always_comb begin
        acc_next = acc_e;
        cnt_next = cnt_e;
        bc_next  = bc_e;
        end_next = end_e;
        if (absorb) begin
            acc_next = acc_e | (ACC_W'(rd_entry.code) << cnt_e[2:0]);
            cnt_next = cnt_e + CNT_W'(rd_entry.len);
            bc_next  = bc_e + TOTAL_W'(rd_entry.len);
            end_next = rd_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            bc_reg       <= '0;
            end_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (do_read) begin
                rd_valid_reg <= 1'b1;
            end else if (absorb) begin
                rd_valid_reg <= 1'b0;
            end
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            bc_reg  <= bc_next;
            end_reg <= end_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg   <= acc_reg[BYTE_W-1:0];
            byte_valid_reg <= (cnt_reg != '0);
            total_reg      <= emit_last ? bc_reg : '0;
            last_reg       <= emit_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_bit_total  = total_reg;
    assign m_last       = last_reg;

    // checks
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_last)
        else $error("empty beat without last");

    a_total_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_bit_total == '0)
        else $error("bit total on non-final beat");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(ACC_W))
        else $error("packer count overflow");

    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg && !absorb |=> rd_valid_reg && $stable(rd_entry))
        else $error("read stage lost while stalled");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && emit_last && !absorb |=> cnt_reg == '0 && bc_reg == '0 && !end_reg)
        else $error("packer not cleared after end of message");

endmodule
